>>> hdl/encoder_wheel_speed_filter_assert.svh
// Assertion macros shared by the encoder wheel speed filter modules.
// No dependencies; included by the modules that carry assertions.
`ifndef ENCODER_WHEEL_SPEED_FILTER_ASSERT_SVH
`define ENCODER_WHEEL_SPEED_FILTER_ASSERT_SVH

`ifndef ASSERT_OFF
// Implication or plain property, checked at every rising clock edge outside reset.
`define EWSF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// A condition that must never hold.
`define EWSF_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define EWSF_ASSERT(lbl, clk, rst_n, prop, msg)
`define EWSF_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

>>> hdl/ewsf_pkg.sv
// Shared widths, constants and types of the encoder wheel speed filter.
// No dependencies; used by every module of the block.
`default_nettype none

package ewsf_pkg;

    // Divider operand widths: the dividend is |window| * 65536000 + den / 2.
    localparam int NUM_W = 58;
    localparam int DEN_W = 48;
    localparam int Q_W   = 33;
    localparam int CNT_W = 6;

    // Shared multiplier operand and product widths.
    localparam int MA_W = 33;
    localparam int MB_W = 17;
    localparam int P_W  = 50;

    // Configuration register indexes.
    localparam logic [1:0] REG_CPR     = 2'd0;
    localparam logic [1:0] REG_MIN_INT = 2'd1;
    localparam logic [1:0] REG_STALL   = 2'd2;
    localparam logic [1:0] REG_CIRC    = 2'd3;

    // Input command codes.
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_REZERO = 1'b1;

    // Scale factors: milliseconds per second and the filter gain 0.2 in Q0.16.
    localparam logic [MB_W-1:0] RPS_SCALE   = 17'd1000;
    localparam logic [MB_W-1:0] FILTER_GAIN = 17'd13107;

    typedef struct packed {
        logic busy;
        logic done;
        logic ovf;
    } div_stat_t;

endpackage

`default_nettype wire

>>> hdl/ewsf_mul.sv
// Shared signed multiplier with a registered product.
// Depends on ewsf_pkg for operand widths.
`default_nettype none

module ewsf_mul (
    input  wire logic                              clk,
    input  wire logic signed [ewsf_pkg::MA_W-1:0] a,
    input  wire logic signed [ewsf_pkg::MB_W-1:0] b,
    output logic signed [ewsf_pkg::P_W-1:0]       p
);

    logic signed [ewsf_pkg::P_W-1:0] p_reg;

    // Both operands are sign-extended to the product width before the multiply.
    always_ff @(posedge clk)
    begin
        p_reg <= ewsf_pkg::P_W'(a) * ewsf_pkg::P_W'(b);
    end

    assign p = p_reg;

endmodule

`default_nettype wire

>>> hdl/ewsf_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, with overflow flag.
// Depends on ewsf_pkg and the assertion macro header.
`default_nettype none
`include "encoder_wheel_speed_filter_assert.svh"

module ewsf_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [ewsf_pkg::NUM_W-1:0]  num,
    input  wire logic [ewsf_pkg::DEN_W-1:0]  den,
    output ewsf_pkg::div_stat_t              stat,
    output logic [ewsf_pkg::Q_W-1:0]         quo
);

    localparam int HI_W = ewsf_pkg::NUM_W - ewsf_pkg::Q_W;

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [ewsf_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic                          ovf_reg, ovf_next;
    logic [ewsf_pkg::DEN_W-1:0]    rem_reg, rem_next;
    logic [ewsf_pkg::Q_W-1:0]      sh_reg, sh_next;
    logic [ewsf_pkg::DEN_W-1:0]    den_reg, den_next;
    logic [ewsf_pkg::DEN_W:0]      trial;
    logic [ewsf_pkg::DEN_W:0]      diff;
    logic                          ge;

    // The quotient overflows 33 bits exactly when the upper dividend bits reach the divisor.
    always_comb
    begin
        trial     = {rem_reg, sh_reg[ewsf_pkg::Q_W-1]};
        diff      = trial - {1'b0, den_reg};
        ge        = trial >= {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        ovf_next  = ovf_reg;
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = ewsf_pkg::CNT_W'(ewsf_pkg::Q_W);
            ovf_next  = {{(ewsf_pkg::DEN_W-HI_W){1'b0}}, num[ewsf_pkg::NUM_W-1:ewsf_pkg::Q_W]} >= den;
            rem_next  = {{(ewsf_pkg::DEN_W-HI_W){1'b0}}, num[ewsf_pkg::NUM_W-1:ewsf_pkg::Q_W]};
            sh_next   = num[ewsf_pkg::Q_W-1:0];
            den_next  = den;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[ewsf_pkg::DEN_W-1:0] : trial[ewsf_pkg::DEN_W-1:0];
            sh_next  = {sh_reg[ewsf_pkg::Q_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == ewsf_pkg::CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ovf_reg <= ovf_next;
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        den_reg <= den_next;
    end

    // Status bits from the top: busy, done, overflow.
    assign stat = {busy_reg, done_reg, ovf_reg};
    assign quo  = sh_reg;

    `EWSF_ASSERT_NEVER(a_div_start_busy, clk, rst_n, start && busy_reg, "divider restarted while busy")
    `EWSF_ASSERT(a_div_done_idle, clk, rst_n, done_reg |-> !busy_reg, "divider done while busy")
    `EWSF_ASSERT(a_div_cnt, clk, rst_n, busy_reg |-> (cnt_reg != '0), "divider busy with no bits left")

endmodule

`default_nettype wire

>>> hdl/encoder_wheel_speed_filter.sv
// Top level of the encoder wheel speed filter: sequencer, state and ports.
// Depends on ewsf_pkg, ewsf_mul, ewsf_div and the assertion macro header.
//
// Usage. Each input word on the s_ channel carries a raw encoder count and a
// millisecond timestamp; s_tuser selects a normal sample (0) or a rezero (1).
// For every input word the block returns exactly one output word on the m_
// channel with the filtered speed in cm/s, the filtered speed in revolutions
// per second (Q16.16) and the running count total.
// Flow: a word that closes a speed window passes through the serial divider
// between acceptance and m_tvalid; any other word skips it. s_tready rises
// with m_tvalid, so no new word is taken until the last one's result is in
// the output register, and a result waiting on a stalled receiver does not
// hold off the next word.
// When the receiver stalls, the result stays in the output register; a second
// finished result waits in the sequencer until the register is taken.
// Reset clears all filter state, the output valid flag and the configuration
// registers to their defaults (1024 counts per revolution, 20 ms interval,
// 200 ms stall timeout, 5222/256 cm circumference). The APB port is always
// ready; the user must write it only while the block is idle (not enforced).
`default_nettype none
`include "encoder_wheel_speed_filter_assert.svh"

module encoder_wheel_speed_filter (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // [31:0] encoder_count, [63:32] now_ms
    input  wire logic        s_tuser,   // [0] command
    // Output stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [79:0]      m_tdata,   // [15:0] speed_cms, [47:16] speed_rps,
                                        // [79:48] total_counts
    // Configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // Sequencer states.
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MOTION = 4'd1;
    localparam logic [3:0] S_DEN    = 4'd2;
    localparam logic [3:0] S_ACC    = 4'd3;
    localparam logic [3:0] S_DIVLD  = 4'd4;
    localparam logic [3:0] S_DIV    = 4'd5;
    localparam logic [3:0] S_FILT   = 4'd6;
    localparam logic [3:0] S_FADD   = 4'd7;
    localparam logic [3:0] S_STALL  = 4'd8;
    localparam logic [3:0] S_CMS    = 4'd9;
    localparam logic [3:0] S_OUT    = 4'd10;

    localparam int P_W = ewsf_pkg::P_W;

    // Configuration registers.
    logic [15:0] cpr_reg, min_int_reg, stall_reg, circ_reg;
    logic        cfg_wr;

    // Control and filter state.
    logic [3:0]  state_reg, state_next;
    logic [31:0] ref_reg, ref_next;
    logic [31:0] sum_reg, sum_next;
    logic [31:0] win_reg, win_next;
    logic [31:0] filt_reg, filt_next;
    logic [31:0] wstart_reg, wstart_next;
    logic [31:0] lmot_reg, lmot_next;
    logic        m_tvalid_reg, m_tvalid_next;

    // Per-word payload holding registers.
    logic        cmd_reg;
    logic [31:0] cur_reg, now_reg;
    logic [31:0] dt_reg, dt_next;
    logic [ewsf_pkg::DEN_W-1:0] den_reg, den_next;
    logic [31:0] rps_reg, rps_next;
    logic [79:0] m_tdata_reg, m_tdata_next;

    // Shared multiplier.
    logic signed [ewsf_pkg::MA_W-1:0] mul_a;
    logic signed [ewsf_pkg::MB_W-1:0] mul_b;
    logic signed [P_W-1:0]            prod;

    // Divider.
    logic                             div_start;
    logic [ewsf_pkg::NUM_W-1:0]       div_num;
    ewsf_pkg::div_stat_t              div_stat;
    logic [ewsf_pkg::Q_W-1:0]         div_quo;

    // Datapath helpers.
    logic signed [32:0] d_full;
    logic [15:0]        d_clamp;
    logic [31:0]        d_ext;
    logic [31:0]        dt_now;
    logic [32:0]        win_abs;
    logic               p_neg;
    logic [P_W-1:0]     p_mag;
    logic [P_W-1:0]     f_rnd;
    logic [P_W-1:0]     c_rnd;
    logic [33:0]        step_mag;
    logic signed [33:0] step;
    logic signed [33:0] fsum;
    logic [31:0]        filt_sat;
    logic [25:0]        cms_mag;
    logic [15:0]        cms;
    logic [31:0]        rps_val;
    logic [15:0]        cpr_eff;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;

    // A zero counts-per-revolution setting behaves as one.
    assign cpr_eff = (cpr_reg == 16'd0) ? 16'd1 : cpr_reg;

    always_comb
    begin
        unique case (paddr[3:2])
            ewsf_pkg::REG_CPR:     prdata = {16'd0, cpr_reg};
            ewsf_pkg::REG_MIN_INT: prdata = {16'd0, min_int_reg};
            ewsf_pkg::REG_STALL:   prdata = {16'd0, stall_reg};
            ewsf_pkg::REG_CIRC:    prdata = {16'd0, circ_reg};
            default:               prdata = 32'd0;
        endcase
    end

    // Count change since the reference, clamped to the int16 range.
    always_comb
    begin
        d_full = $signed({cur_reg[31], cur_reg}) - $signed({ref_reg[31], ref_reg});
        if (d_full > 33'sd32767)
        begin
            d_clamp = 16'h7FFF;
        end
        else if (d_full < -33'sd32768)
        begin
            d_clamp = 16'h8000;
        end
        else
        begin
            d_clamp = d_full[15:0];
        end
        d_ext   = {{16{d_clamp[15]}}, d_clamp};
        dt_now  = now_reg - wstart_reg;
        win_abs = win_reg[31] ? (33'd0 - {1'b1, win_reg}) : {1'b0, win_reg};
    end

    // Operand selection for the shared multiplier. The product is registered
    // and appears in the following state.
    always_comb
    begin
        unique case (state_reg)
            S_DEN:
            begin
                mul_a = {1'b0, dt_reg};
                mul_b = {1'b0, cpr_eff};
            end
            S_ACC:
            begin
                mul_a = win_abs;
                mul_b = ewsf_pkg::RPS_SCALE;
            end
            S_FILT:
            begin
                mul_a = $signed({rps_reg[31], rps_reg}) - $signed({filt_reg[31], filt_reg});
                mul_b = ewsf_pkg::FILTER_GAIN;
            end
            default:
            begin
                mul_a = {filt_reg[31], filt_reg};
                mul_b = {1'b0, circ_reg};
            end
        endcase
    end

    ewsf_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    // Dividend: |window| * 1000 * 65536 plus half the divisor for rounding.
    assign div_num = {1'b0, prod[40:0], 16'd0} + {11'd0, den_reg[ewsf_pkg::DEN_W-1:1]};
    assign div_start = (state_reg == S_DIVLD);

    ewsf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (den_reg),
        .stat  (div_stat),
        .quo   (div_quo)
    );

    // Quotient to signed Q16.16 speed with saturation.
    always_comb
    begin
        if (win_reg[31])
        begin
            if (div_stat.ovf || (div_quo > 33'h080000000))
            begin
                rps_val = 32'h80000000;
            end
            else
            begin
                rps_val = 32'd0 - div_quo[31:0];
            end
        end
        else if (div_stat.ovf || div_quo[32] || div_quo[31])
        begin
            rps_val = 32'h7FFFFFFF;
        end
        else
        begin
            rps_val = div_quo[31:0];
        end
    end

    // Round-half-away scaling of the current product, used both for the
    // filter step (shift by 16) and for the cm/s output (shift by 24).
    always_comb
    begin
        p_neg    = prod[P_W-1];
        p_mag    = p_neg ? (P_W'(0) - prod) : prod;
        f_rnd    = p_mag + (P_W'(1) << 15);
        c_rnd    = p_mag + (P_W'(1) << 23);
        step_mag = f_rnd[49:16];
        step     = p_neg ? (34'sd0 - $signed(step_mag)) : $signed(step_mag);
        fsum     = $signed({{2{filt_reg[31]}}, filt_reg}) + step;
        if (fsum > 34'sd2147483647)
        begin
            filt_sat = 32'h7FFFFFFF;
        end
        else if (fsum < -34'sd2147483648)
        begin
            filt_sat = 32'h80000000;
        end
        else
        begin
            filt_sat = fsum[31:0];
        end
        cms_mag = c_rnd[49:24];
        if (!p_neg)
        begin
            cms = (cms_mag > 26'd32767) ? 16'h7FFF : cms_mag[15:0];
        end
        else
        begin
            cms = (cms_mag > 26'd32768) ? 16'h8000 : (16'd0 - cms_mag[15:0]);
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next    = state_reg;
        ref_next      = ref_reg;
        sum_next      = sum_reg;
        win_next      = win_reg;
        filt_next     = filt_reg;
        wstart_next   = wstart_reg;
        lmot_next     = lmot_reg;
        dt_next       = dt_reg;
        den_next      = den_reg;
        rps_next      = rps_reg;
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_MOTION;
                end
            end
            S_MOTION:
            begin
                state_next = S_STALL;
                if (cmd_reg == ewsf_pkg::CMD_REZERO)
                begin
                    sum_next    = 32'd0;
                    win_next    = 32'd0;
                    filt_next   = 32'd0;
                    wstart_next = 32'd0;
                    lmot_next   = 32'd0;
                    ref_next    = cur_reg;
                end
                else if (d_full != 33'sd0)
                begin
                    sum_next  = sum_reg + d_ext;
                    win_next  = win_reg + d_ext;
                    ref_next  = cur_reg;
                    lmot_next = now_reg;
                    // A zero start time means the window has not started yet.
                    if (wstart_reg == 32'd0)
                    begin
                        wstart_next = now_reg;
                    end
                    else if ((dt_now >= {16'd0, min_int_reg}) && (dt_now != 32'd0))
                    begin
                        wstart_next = now_reg;
                        dt_next     = dt_now;
                        state_next  = S_DEN;
                    end
                end
            end
            S_DEN:
            begin
                state_next = S_ACC;
            end
            S_ACC:
            begin
                den_next   = prod[ewsf_pkg::DEN_W-1:0];
                state_next = S_DIVLD;
            end
            S_DIVLD:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    rps_next   = rps_val;
                    state_next = S_FILT;
                end
            end
            S_FILT:
            begin
                state_next = S_FADD;
            end
            S_FADD:
            begin
                filt_next  = filt_sat;
                win_next   = 32'd0;
                state_next = S_STALL;
            end
            S_STALL:
            begin
                if ((lmot_reg != 32'd0) && ((now_reg - lmot_reg) > {16'd0, stall_reg}))
                begin
                    filt_next = 32'd0;
                end
                state_next = S_CMS;
            end
            S_CMS:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tdata_next  = {sum_reg, filt_reg, cms};
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            ref_reg      <= 32'd0;
            sum_reg      <= 32'd0;
            win_reg      <= 32'd0;
            filt_reg     <= 32'd0;
            wstart_reg   <= 32'd0;
            lmot_reg     <= 32'd0;
            m_tvalid_reg <= 1'b0;
            cpr_reg      <= 16'd1024;
            min_int_reg  <= 16'd20;
            stall_reg    <= 16'd200;
            circ_reg     <= 16'd5222;
        end
        else
        begin
            state_reg    <= state_next;
            ref_reg      <= ref_next;
            sum_reg      <= sum_next;
            win_reg      <= win_next;
            filt_reg     <= filt_next;
            wstart_reg   <= wstart_next;
            lmot_reg     <= lmot_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr)
            begin
                unique case (paddr[3:2])
                    ewsf_pkg::REG_CPR:     cpr_reg     <= pwdata[15:0];
                    ewsf_pkg::REG_MIN_INT: min_int_reg <= pwdata[15:0];
                    ewsf_pkg::REG_STALL:   stall_reg   <= pwdata[15:0];
                    ewsf_pkg::REG_CIRC:    circ_reg    <= pwdata[15:0];
                    default:               cpr_reg     <= cpr_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            cmd_reg <= s_tuser;
            cur_reg <= s_tdata[31:0];
            now_reg <= s_tdata[63:32];
        end
        dt_reg      <= dt_next;
        den_reg     <= den_next;
        rps_reg     <= rps_next;
        m_tdata_reg <= m_tdata_next;
    end

    `EWSF_ASSERT(a_idle_div, clk, rst_n, s_tready |-> !div_stat.busy, "input ready while dividing")
    `EWSF_ASSERT(a_done_state, clk, rst_n, div_stat.done |-> (state_reg == S_DIV), "divider result not awaited")
    `EWSF_ASSERT(a_out_load, clk, rst_n, $rose(m_tvalid_reg) |-> $past(state_reg == S_OUT), "output loaded outside the output state")

endmodule

`default_nettype wire

>>> test/encoder_wheel_speed_filter_tb.sv
// Self-checking testbench for the encoder wheel speed filter.
// Depends on ewsf_pkg and the encoder_wheel_speed_filter top level; predicts each output word.
`timescale 1ns / 1ps

module encoder_wheel_speed_filter_tb;

    localparam int CYCLE_LIMIT = 800000;
    localparam int ITEMS_PER_SEG = 320;
    localparam int NUM_SEGS = 6;

    typedef struct packed {
        bit [15:0] cms;
        bit [31:0] rps;
        bit [31:0] total;
    } speed_res_t;

    typedef enum {ROW_ITEM, ROW_CFG} row_kind_t;

    // One row of the directed table. For a register row, a holds the index and b the value.
    typedef struct {
        row_kind_t  kind;
        bit         cmd;
        bit [31:0]  a;
        bit [31:0]  b;
        bit         typed;
        speed_res_t res;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    encoder_wheel_speed_filter u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Predictor copy of the configuration and the filter state.
    bit [15:0] cfg_cpr   = 16'd1024;
    bit [15:0] cfg_min   = 16'd20;
    bit [15:0] cfg_stall = 16'd200;
    bit [15:0] cfg_circ  = 16'd5222;

    bit [31:0] prev_count    = '0;
    bit [31:0] count_total   = '0;
    bit [31:0] window_acc    = '0;
    int        filt_rps      = 0;
    bit [31:0] window_t0     = '0;
    bit [31:0] last_move_ms  = '0;

    speed_res_t pending_speeds[$];
    dir_row_t   dir_rows[$];

    int err_count = 0;
    int result_idx = 0;
    int cycles = 0;
    int src_idle_pct = 0;
    int dst_idle_pct = 0;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Divide by 2^s, rounding to nearest with halves away from zero.
    function automatic longint round_half_away(longint v, int unsigned s);
        longint unsigned m;
        m = (v < 0) ? longint'(-v) : longint'(v);
        m = (m + (64'd1 << (s - 1))) >> s;
        return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic int clamp_i32(longint v);
        if (v > 64'sd2147483647) return 32'h7FFFFFFF;
        if (v < -64'sd2147483648) return 32'h80000000;
        return int'(v);
    endfunction

    // Closes the speed window: instantaneous rps in Q16.16, then the 0.2 filter step.
    function automatic void close_speed_window(bit [31:0] dt);
        longint unsigned den, mag, q;
        longint acc, gain_step;
        int rps;
        den = longint'((cfg_cpr == 0) ? 16'd1 : cfg_cpr) * longint'(dt);
        acc = longint'($signed(window_acc));
        // 65536000 is 1000 ms per second times the Q16.16 scale.
        mag = longint'((acc < 0) ? -acc : acc) * 64'd65536000;
        q = (mag + den / 2) / den;
        if (acc < 0)
            rps = (q > 64'h80000000) ? 32'h80000000 : int'(-longint'(q));
        else
            rps = (q > 64'h7FFFFFFF) ? 32'h7FFFFFFF : int'(q);
        gain_step = round_half_away((longint'(rps) - longint'(filt_rps)) *
                                    longint'(ewsf_pkg::FILTER_GAIN), 16);
        filt_rps = clamp_i32(longint'(filt_rps) + gain_step);
        window_acc = '0;
    endfunction

    function automatic speed_res_t predict_speed(bit cmd, bit [31:0] cur, bit [31:0] now);
        longint d, cms;
        bit [31:0] dt;
        speed_res_t r;
        if (cmd == ewsf_pkg::CMD_REZERO)
        begin
            count_total  = '0;
            window_acc   = '0;
            filt_rps     = 0;
            window_t0    = '0;
            last_move_ms = '0;
            prev_count   = cur;
        end
        else
        begin
            d = longint'($signed(cur)) - longint'($signed(prev_count));
            if (d != 0)
            begin
                if (d > 32767) d = 32767;
                if (d < -32768) d = -32768;
                count_total += 32'(d);
                window_acc  += 32'(d);
                // A start time of zero means the window never started.
                if (window_t0 == 0)
                begin
                    window_t0 = now;
                end
                else
                begin
                    dt = now - window_t0;
                    if (!(dt < cfg_min || dt == 0))
                    begin
                        window_t0 = now;
                        close_speed_window(dt);
                    end
                end
                prev_count   = cur;
                last_move_ms = now;
            end
            if (last_move_ms != 0 && (now - last_move_ms) > cfg_stall)
                filt_rps = 0;
        end
        cms = round_half_away(longint'(filt_rps) * longint'(cfg_circ), 24);
        if (cms > 32767) cms = 32767;
        if (cms < -32768) cms = -32768;
        r.cms   = 16'(cms);
        r.rps   = filt_rps;
        r.total = count_total;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        err_count++;
        $display("ERROR word %0d %s: got %h, expected %h", result_idx, what, got, want);
    endtask

    function automatic dir_row_t item_row(bit cmd, bit [31:0] cnt, bit [31:0] now);
        dir_row_t row;
        row.kind = ROW_ITEM;
        row.cmd = cmd;
        row.a = cnt;
        row.b = now;
        row.typed = 1'b0;
        row.res = '0;
        return row;
    endfunction

    // A row whose result is obvious: speed fields zero, only the total is given.
    function automatic dir_row_t still_row(bit cmd, bit [31:0] cnt, bit [31:0] now,
                                           bit [31:0] total);
        dir_row_t row;
        row = item_row(cmd, cnt, now);
        row.typed = 1'b1;
        row.res.total = total;
        return row;
    endfunction

    function automatic dir_row_t cfg_row(bit [1:0] idx, bit [15:0] val);
        dir_row_t row;
        row = item_row(ewsf_pkg::CMD_SAMPLE, 32'(idx), 32'(val));
        row.kind = ROW_CFG;
        return row;
    endfunction

    // Output side: compare each accepted word with the oldest expectation.
    always @(posedge clk)
    begin
        speed_res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_speeds.size() == 0)
            begin
                report_mismatch("unexpected word", m_tdata[31:0], 32'h0);
            end
            else
            begin
                want = pending_speeds.pop_front();
                if (m_tdata[15:0] !== want.cms)
                    report_mismatch("speed_cms", 32'(m_tdata[15:0]), 32'(want.cms));
                if (m_tdata[47:16] !== want.rps)
                    report_mismatch("speed_rps", m_tdata[47:16], want.rps);
                if (m_tdata[79:48] !== want.total)
                    report_mismatch("total_counts", m_tdata[79:48], want.total);
            end
            result_idx++;
        end
    end

    // Receiver back-pressure, changed at the falling edge.
    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= dst_idle_pct);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("encoder_wheel_speed_filter: mismatch");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_word(bit cmd, bit [31:0] cnt, bit [31:0] now,
                             bit typed, speed_res_t typed_res);
        speed_res_t r;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {now, cnt};
        s_tuser  <= cmd;
        do @(posedge clk); while (!s_tready);
        r = predict_speed(cmd, cnt, now);
        pending_speeds.push_back(typed ? typed_res : r);
        @(negedge clk);
    endtask

    // Holds the sender off until every pending word has come out.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending_speeds.size() != 0) @(negedge clk);
    endtask

    // Register write followed by a back-to-back read-back; called at a falling edge.
    task automatic write_reg(bit [1:0] idx, bit [15:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(val);
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata[15:0] !== val)
            report_mismatch("register read-back", 32'(prdata[15:0]), 32'(val));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        case (idx)
            ewsf_pkg::REG_CPR:     cfg_cpr   = val;
            ewsf_pkg::REG_MIN_INT: cfg_min   = val;
            ewsf_pkg::REG_STALL:   cfg_stall = val;
            ewsf_pkg::REG_CIRC:    cfg_circ  = val;
            default: ;
        endcase
    endtask

    initial
    begin
        int r, vel, pause_at;
        bit cmd;
        bit [31:0] gen_cnt, gen_now;
        bit [15:0] seg_cfg[4];

        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = ewsf_pkg::CMD_SAMPLE;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;

        // Reset defaults, count extremes, clamping, motion at time zero, the stall
        // timeout, rezero, and a window that closes across the timestamp wrap.
        dir_rows.push_back(still_row(ewsf_pkg::CMD_SAMPLE, 32'h0000_0000, 32'd0, 32'd0));
        dir_rows.push_back(still_row(ewsf_pkg::CMD_SAMPLE, 32'd100, 32'd0, 32'd100));
        dir_rows.push_back(still_row(ewsf_pkg::CMD_SAMPLE, 32'h7FFF_FFFF, 32'd5, 32'd32867));
        dir_rows.push_back(still_row(ewsf_pkg::CMD_SAMPLE, 32'h8000_0000, 32'd10, 32'd99));
        dir_rows.push_back(item_row(ewsf_pkg::CMD_SAMPLE, 32'h8000_03E8, 32'd30));
        dir_rows.push_back(still_row(ewsf_pkg::CMD_SAMPLE, 32'h8000_03E8, 32'd300, 32'd1099));
        dir_rows.push_back(still_row(ewsf_pkg::CMD_REZERO, 32'h1234_5678, 32'hFFFF_FFFF, 32'd0));
        dir_rows.push_back(still_row(ewsf_pkg::CMD_SAMPLE, 32'h1234_586C, 32'hFFFF_FFF0,
                                     32'd500));
        dir_rows.push_back(item_row(ewsf_pkg::CMD_SAMPLE, 32'h1234_5A60, 32'h0000_0010));
        dir_rows.push_back(item_row(ewsf_pkg::CMD_SAMPLE, 32'h1234_5A60, 32'h0000_0010));
        // One count per revolution and a zero interval drive rps into saturation.
        dir_rows.push_back(cfg_row(ewsf_pkg::REG_CPR, 16'd1));
        dir_rows.push_back(cfg_row(ewsf_pkg::REG_MIN_INT, 16'd0));
        dir_rows.push_back(cfg_row(ewsf_pkg::REG_STALL, 16'hFFFF));
        dir_rows.push_back(cfg_row(ewsf_pkg::REG_CIRC, 16'hFFFF));
        dir_rows.push_back(still_row(ewsf_pkg::CMD_REZERO, 32'd0, 32'd1, 32'd0));
        dir_rows.push_back(still_row(ewsf_pkg::CMD_SAMPLE, 32'd32767, 32'd2, 32'd32767));
        dir_rows.push_back(still_row(ewsf_pkg::CMD_SAMPLE, 32'd65534, 32'd2, 32'd65534));
        dir_rows.push_back(item_row(ewsf_pkg::CMD_SAMPLE, 32'd98301, 32'd3));
        dir_rows.push_back(item_row(ewsf_pkg::CMD_SAMPLE, 32'd131068, 32'd4));
        dir_rows.push_back(item_row(ewsf_pkg::CMD_SAMPLE, 32'd163835, 32'd5));
        dir_rows.push_back(item_row(ewsf_pkg::CMD_SAMPLE, 32'd196602, 32'd6));
        dir_rows.push_back(item_row(ewsf_pkg::CMD_SAMPLE, 32'd163834, 32'd7));
        dir_rows.push_back(item_row(ewsf_pkg::CMD_SAMPLE, 32'd131066, 32'd8));
        dir_rows.push_back(item_row(ewsf_pkg::CMD_SAMPLE, 32'd98298, 32'd9));
        dir_rows.push_back(item_row(ewsf_pkg::CMD_SAMPLE, 32'd65530, 32'd10));
        // Zero counts per revolution, stall timeout and circumference; longest interval.
        dir_rows.push_back(cfg_row(ewsf_pkg::REG_CPR, 16'd0));
        dir_rows.push_back(cfg_row(ewsf_pkg::REG_STALL, 16'd0));
        dir_rows.push_back(cfg_row(ewsf_pkg::REG_CIRC, 16'd0));
        dir_rows.push_back(cfg_row(ewsf_pkg::REG_MIN_INT, 16'hFFFF));
        dir_rows.push_back(still_row(ewsf_pkg::CMD_SAMPLE, 32'd65530, 32'd11, 32'd65530));
        dir_rows.push_back(item_row(ewsf_pkg::CMD_SAMPLE, 32'd65531, 32'd12));
        dir_rows.push_back(item_row(ewsf_pkg::CMD_SAMPLE, 32'hFFFF_FFFF, 32'd0));
        dir_rows.push_back(item_row(ewsf_pkg::CMD_SAMPLE, 32'hFFFF_FFFF, 32'h8000_0000));
        dir_rows.push_back(cfg_row(ewsf_pkg::REG_MIN_INT, 16'd1));
        dir_rows.push_back(item_row(ewsf_pkg::CMD_SAMPLE, 32'd99, 32'h8000_0001));

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        src_idle_pct = 26;
        dst_idle_pct = 62;
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
            begin
                wait_idle();
                write_reg(dir_rows[i].a[1:0], dir_rows[i].b[15:0]);
            end
            else
            begin
                send_word(dir_rows[i].cmd, dir_rows[i].a, dir_rows[i].b,
                          dir_rows[i].typed, dir_rows[i].res);
            end
        end

        // Random segments: each one has its own settings and a steady drift of the
        // count, with rezeros, jumps, standstills and pure noise mixed in.
        for (int seg = 0; seg < NUM_SEGS; seg++)
        begin
            src_idle_pct = (seg < 2) ? 26 : (seg < 4) ? 62 : 0;
            dst_idle_pct = (seg < 2) ? 62 : (seg < 4) ? 26 : 0;
            case (seg)
                0: seg_cfg = '{16'd1024, 16'd20, 16'd200, 16'd5222};
                2: seg_cfg = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
                3: seg_cfg = '{16'd1, 16'd0, 16'd0, 16'hFFFF};
                default: seg_cfg = '{16'($urandom_range(1, 4096)),
                                     16'($urandom_range(0, 40)),
                                     16'($urandom_range(0, 600)),
                                     16'($urandom_range(0, 65535))};
            endcase
            wait_idle();
            write_reg(ewsf_pkg::REG_CPR, seg_cfg[0]);
            write_reg(ewsf_pkg::REG_MIN_INT, seg_cfg[1]);
            write_reg(ewsf_pkg::REG_STALL, seg_cfg[2]);
            write_reg(ewsf_pkg::REG_CIRC, seg_cfg[3]);

            vel      = int'($urandom_range(0, 400)) - 200;
            gen_cnt  = $urandom;
            gen_now  = (seg == 3) ? 32'hFFFF_FE00 : $urandom_range(1, 100000);
            pause_at = $urandom_range(20, ITEMS_PER_SEG - 20);
            // Start each segment from a known reference.
            send_word(ewsf_pkg::CMD_REZERO, gen_cnt, gen_now, 1'b0, '0);

            for (int k = 0; k < ITEMS_PER_SEG; k++)
            begin
                if (k == pause_at)
                    wait_idle();
                cmd = ewsf_pkg::CMD_SAMPLE;
                r = $urandom_range(0, 99);
                if (r < 2)
                begin
                    cmd = ewsf_pkg::CMD_REZERO;
                    gen_cnt = $urandom;
                end
                else if (r < 6)
                begin
                    gen_cnt = $urandom;
                    gen_now = $urandom;
                end
                else
                begin
                    r = $urandom_range(0, 99);
                    if (r == 0)
                        gen_now += $urandom_range(0, 100000);
                    else if (r < 6)
                        gen_now += $urandom_range(0, 700);
                    else
                        gen_now += $urandom_range(0, 4);
                    if ($urandom_range(0, 199) == 0)
                        gen_now = '0;
                    r = $urandom_range(0, 9);
                    if (r == 2)
                        gen_cnt += 32'(int'($urandom_range(0, 200000)) - 100000);
                    else if (r > 2)
                        gen_cnt += 32'(vel + int'($urandom_range(0, 40)) - 20);
                end
                send_word(cmd, gen_cnt, gen_now, 1'b0, '0);
            end
        end

        wait_idle();
        repeat (100) @(posedge clk);
        if (pending_speeds.size() != 0)
            report_mismatch("words never produced", 32'(pending_speeds.size()), 32'h0);
        if (err_count == 0)
            $display("encoder_wheel_speed_filter: match");
        else
            $display("encoder_wheel_speed_filter: mismatch");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/ewsf_pkg.sv
hdl/ewsf_mul.sv
hdl/ewsf_div.sv
hdl/encoder_wheel_speed_filter.sv
test/encoder_wheel_speed_filter_tb.sv
